FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by halftone_density_field_update
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/hdfu_pkg.sv
// ----------------------------------------------------------------------------
// hdfu_pkg
// Types and constants of the halftone density field update block.
// ----------------------------------------------------------------------------
package hdfu_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 24;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DENS_W = 48;
  localparam int LVL_W  = 12;
  localparam int DIM_W  = 7;
  localparam int ASP_W  = 4;
  localparam int SQ_W   = 2 * ASP_W;            // squared aspect weight
  localparam int NUM_W  = 2 * SQ_W + FRAC_BITS; // dividend width
  localparam int DIST_W = 6;                    // wrap distance, at most 32
  localparam int DSQ_W  = 11;                   // squared distance, at most 1024
  localparam int DEN_W  = 19;                   // weighted sum of squares
  localparam int CFG_IDX_W = 2;

  localparam logic [DENS_W-1:0] DMASK    = '1;
  localparam logic [DENS_W-1:0] ONE_UNIT = DENS_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PLACE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_ASPECT_X = 2'd2,
    CFG_ASPECT_Y = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [LVL_W-1:0]  dot_level;
  } in_item_t;

  typedef struct packed {
    logic [DENS_W-1:0] cell_density;
    logic [LVL_W-1:0]  cell_level;
    logic              cell_filled;
    logic [DENS_W-1:0] min_density;
    logic [DENS_W-1:0] max_density;
    logic [DENS_W-1:0] density_range;
  } out_item_t;

endpackage

FILE: design/halftone_density_field_update.sv
// ----------------------------------------------------------------------------
// halftone_density_field_update
// Toroidal inverse-distance density field for stochastic screen generation.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_data when start is high and busy is low. Every item
//   gives one result beat on out_data, marked by out_strobe for one cycle;
//   the receiver takes it unconditionally.
//   Answers: kind 3 or a cell outside the field answers in the cycle after
//   acceptance; a read answers from ST_READ after the registered memory read;
//   a clear makes one write per memory entry; a place streams the w*h cells
//   through a 40-stage pipelined restoring divider, one cell per cycle, then
//   the pipeline drains. The density memory has a single write port.
//   Configuration writes go through cfg_valid/cfg_ready (always ready); the
//   user must make them while the block is idle; the block does not enforce it.
//   After reset the block sweeps every density memory entry to zero with busy
//   high and gives no result; configuration beats are taken as ever.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module halftone_density_field_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  hdfu_pkg::in_item_t              in_data,
  output logic                            out_strobe,
  output hdfu_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hdfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdfu_pkg::DIM_W-1:0]      cfg_data
);

  localparam int NW = hdfu_pkg::NUM_W;
  localparam int DW = hdfu_pkg::DENS_W;
  localparam int AW = hdfu_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_PLACE, ST_SWEEP, ST_DRAIN
  } state_t;

  // wrap-around distance on a ring of n cells
  function automatic logic [hdfu_pkg::DIST_W-1:0] wrap_dist(
    input logic [hdfu_pkg::COL_W-1:0] a,
    input logic [hdfu_pkg::COL_W-1:0] b,
    input logic [hdfu_pkg::DIM_W-1:0] n
  );
    logic [hdfu_pkg::DIST_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if ({1'b0, d} > (n >> 1)) begin
      d = hdfu_pkg::DIST_W'(n - {1'b0, d});
    end
    return d;
  endfunction

  // configuration registers
  logic [hdfu_pkg::DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [hdfu_pkg::ASP_W-1:0] cfg_ax_r, cfg_ay_r;
  logic [hdfu_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [hdfu_pkg::ASP_W-1:0] ax_eff, ay_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= hdfu_pkg::DIM_W'(64);
      cfg_h_r  <= hdfu_pkg::DIM_W'(64);
      cfg_ax_r <= hdfu_pkg::ASP_W'(1);
      cfg_ay_r <= hdfu_pkg::ASP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (hdfu_pkg::cfg_idx_t'(cfg_index))
        hdfu_pkg::CFG_WIDTH:    cfg_w_r  <= cfg_data;
        hdfu_pkg::CFG_HEIGHT:   cfg_h_r  <= cfg_data;
        hdfu_pkg::CFG_ASPECT_X: cfg_ax_r <= cfg_data[hdfu_pkg::ASP_W-1:0];
        hdfu_pkg::CFG_ASPECT_Y: cfg_ay_r <= cfg_data[hdfu_pkg::ASP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions and weights
  always_comb begin
    if (cfg_w_r == '0) w_eff = hdfu_pkg::DIM_W'(1);
    else if (cfg_w_r > hdfu_pkg::DIM_W'(hdfu_pkg::MAX_WIDTH))
      w_eff = hdfu_pkg::DIM_W'(hdfu_pkg::MAX_WIDTH);
    else w_eff = cfg_w_r;
    if (cfg_h_r == '0) h_eff = hdfu_pkg::DIM_W'(1);
    else if (cfg_h_r > hdfu_pkg::DIM_W'(hdfu_pkg::MAX_HEIGHT))
      h_eff = hdfu_pkg::DIM_W'(hdfu_pkg::MAX_HEIGHT);
    else h_eff = cfg_h_r;
    ax_eff = (cfg_ax_r == '0) ? hdfu_pkg::ASP_W'(1) : cfg_ax_r;
    ay_eff = (cfg_ay_r == '0) ? hdfu_pkg::ASP_W'(1) : cfg_ay_r;
  end

  // control and item registers
  state_t                       state_r;
  logic [AW-1:0]                clr_cnt_r;
  logic                         clr_report_r;
  logic [hdfu_pkg::COL_W-1:0]   col_r, x_r;
  logic [hdfu_pkg::ROW_W-1:0]   row_r, y_r;
  logic [hdfu_pkg::LVL_W-1:0]   lvl_r;
  logic [hdfu_pkg::SQ_W-1:0]    rx2_r, ry2_r;
  logic [NW-1:0]                num_r;
  logic [DW-1:0]                min_r, max_r, range_r;
  logic [DW-1:0]                lo_r, hi_r;
  logic                         any_r;
  hdfu_pkg::out_item_t          out_data_r;
  logic                         out_strobe_r;

  // memories: {filled, density} and level
  logic [DW:0]                  dens_mem [hdfu_pkg::CELLS];
  logic [hdfu_pkg::LVL_W-1:0]   lvl_mem  [hdfu_pkg::CELLS];
  logic [DW:0]                  dens_q;
  logic [hdfu_pkg::LVL_W-1:0]   lvl_q;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [DW:0]                  wr_data;
  logic                         wr_en;

  // pipeline
  logic                         s1_v_r, s2_v_r;
  logic [AW-1:0]                s1_addr_r, s2_addr_r;
  logic [hdfu_pkg::DIST_W-1:0]  s1_dx_r, s1_dy_r;
  logic [hdfu_pkg::DSQ_W-1:0]   s2_dx2_r, s2_dy2_r;
  logic [DW-1:0]                s2_old_r;
  logic [NW:0]                  dv_r;
  logic [hdfu_pkg::DEN_W-1:0]   drem_r  [NW+1];
  logic [hdfu_pkg::DEN_W-1:0]   dden_r  [NW+1];
  logic [NW-1:0]                dq_r    [NW+1];
  logic [DW-1:0]                dold_r  [NW+1];
  logic [AW-1:0]                daddr_r [NW+1];
  logic                         dzero_r [NW+1];
  logic                         pipe_busy;

  logic [DW:0]                  wb_sum;
  logic [DW-1:0]                wb_val;
  logic                         last_cell;
  logic [DW-1:0]                fin_min, fin_max, fin_rng;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign pipe_busy  = s1_v_r || s2_v_r || (|dv_r);
  assign last_cell  = (x_r == hdfu_pkg::COL_W'(w_eff - 1'b1)) &&
                      (y_r == hdfu_pkg::ROW_W'(h_eff - 1'b1));

  // memory port selection
  always_comb begin
    rd_addr = (state_r == ST_IDLE) ? {in_data.row, in_data.col} : {y_r, x_r};
    wr_en   = 1'b0;
    wr_addr = daddr_r[NW];
    wr_data = {1'b0, wb_val};
    priority if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (state_r == ST_PLACE) begin
      wr_en   = 1'b1;
      wr_addr = {row_r, col_r};
      wr_data = {1'b1, hdfu_pkg::DMASK};
    end else if (dv_r[NW]) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dens_mem[wr_addr] <= wr_data;
    end
    if (state_r == ST_PLACE) begin
      lvl_mem[{row_r, col_r}] <= lvl_r;
    end
    dens_q <= dens_mem[rd_addr];
    lvl_q  <= lvl_mem[rd_addr];
  end

  // front of the pipeline: distance, squares, weighted denominator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      s1_v_r  <= (state_r == ST_SWEEP);
      s2_v_r  <= s1_v_r && !dens_q[DW];
      dv_r[0] <= s2_v_r;
    end
    s1_addr_r  <= {y_r, x_r};
    s1_dx_r    <= wrap_dist(col_r, x_r, w_eff);
    s1_dy_r    <= wrap_dist(row_r, y_r, h_eff);
    s2_addr_r  <= s1_addr_r;
    s2_old_r   <= dens_q[DW-1:0];
    s2_dx2_r   <= hdfu_pkg::DSQ_W'(s1_dx_r * s1_dx_r);
    s2_dy2_r   <= hdfu_pkg::DSQ_W'(s1_dy_r * s1_dy_r);
    daddr_r[0] <= s2_addr_r;
    dold_r[0]  <= s2_old_r;
    dden_r[0]  <= hdfu_pkg::DEN_W'(s2_dx2_r * ry2_r) + hdfu_pkg::DEN_W'(s2_dy2_r * rx2_r);
    drem_r[0]  <= '0;
    dq_r[0]    <= '0;
    dzero_r[0] <= (s2_dx2_r == '0) && (s2_dy2_r == '0);
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [hdfu_pkg::DEN_W:0] trial;
    logic                     ge;
    assign trial = {drem_r[k], num_r[NW-1-k]};
    assign ge    = (trial >= {1'b0, dden_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      drem_r[k+1]  <= ge ? hdfu_pkg::DEN_W'(trial - {1'b0, dden_r[k]})
                         : hdfu_pkg::DEN_W'(trial);
      dq_r[k+1]    <= {dq_r[k][NW-2:0], ge};
      dden_r[k+1]  <= dden_r[k];
      dold_r[k+1]  <= dold_r[k];
      daddr_r[k+1] <= daddr_r[k];
      dzero_r[k+1] <= dzero_r[k];
    end
  end

  // saturating accumulate at writeback
  always_comb begin
    wb_sum = {1'b0, dold_r[NW]} +
             (dzero_r[NW] ? {1'b0, hdfu_pkg::DMASK} : (DW + 1)'(dq_r[NW]));
    wb_val = wb_sum[DW] ? hdfu_pkg::DMASK : wb_sum[DW-1:0];
  end

  // final statistics of a place
  always_comb begin
    fin_min = any_r ? lo_r : '0;
    fin_max = any_r ? hi_r : '0;
    fin_rng = fin_max - fin_min;
    if (fin_rng == '0) fin_rng = hdfu_pkg::ONE_UNIT;
  end

  // running min and max over written cells
  always_ff @(posedge clk) begin
    if (state_r == ST_PLACE) begin
      lo_r  <= hdfu_pkg::DMASK;
      hi_r  <= '0;
      any_r <= 1'b0;
    end else if (dv_r[NW]) begin
      if (wb_val < lo_r) lo_r <= wb_val;
      if (wb_val > hi_r) hi_r <= wb_val;
      any_r <= 1'b1;
    end
  end

  // sequencer with registered result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_strobe_r <= 1'b0;
      min_r        <= '0;
      max_r        <= '0;
      range_r      <= hdfu_pkg::ONE_UNIT;
      x_r          <= '0;
      y_r          <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
            min_r   <= '0;
            max_r   <= '0;
            range_r <= hdfu_pkg::ONE_UNIT;
            if (clr_report_r) begin
              out_strobe_r <= 1'b1;
              out_data_r   <= '{cell_density: '0, cell_level: '0, cell_filled: 1'b0,
                                min_density: '0, max_density: '0,
                                density_range: hdfu_pkg::ONE_UNIT};
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            col_r <= in_data.col;
            row_r <= in_data.row;
            lvl_r <= in_data.dot_level;
            rx2_r <= hdfu_pkg::SQ_W'(ax_eff * ax_eff);
            ry2_r <= hdfu_pkg::SQ_W'(ay_eff * ay_eff);
            x_r   <= '0;
            y_r   <= '0;
            priority if (in_data.kind == hdfu_pkg::KIND_CLEAR) begin
              state_r      <= ST_CLEAR;
              clr_cnt_r    <= '0;
              clr_report_r <= 1'b1;
            end else if ((in_data.kind == hdfu_pkg::KIND_PLACE ||
                          in_data.kind == hdfu_pkg::KIND_READ) &&
                         {1'b0, in_data.col} < w_eff &&
                         {1'b0, in_data.row} < h_eff) begin
              state_r <= (in_data.kind == hdfu_pkg::KIND_PLACE) ? ST_PLACE : ST_READ;
            end else begin
              out_strobe_r <= 1'b1;
              out_data_r   <= '{cell_density: '0, cell_level: '0, cell_filled: 1'b0,
                                min_density: min_r, max_density: max_r,
                                density_range: range_r};
            end
          end
        end
        ST_READ: begin
          state_r      <= ST_IDLE;
          out_strobe_r <= 1'b1;
          out_data_r   <= '{
            cell_density: dens_q[DW] ? hdfu_pkg::DMASK : dens_q[DW-1:0],
            cell_level:   dens_q[DW] ? lvl_q : '0,
            cell_filled:  dens_q[DW],
            min_density: min_r, max_density: max_r, density_range: range_r};
        end
        ST_PLACE: begin
          num_r   <= NW'(rx2_r * ry2_r) << hdfu_pkg::FRAC_BITS;
          state_r <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (last_cell) begin
            state_r <= ST_DRAIN;
          end else if (x_r == hdfu_pkg::COL_W'(w_eff - 1'b1)) begin
            x_r <= '0;
            y_r <= y_r + 1'b1;
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state_r      <= ST_IDLE;
            min_r        <= fin_min;
            max_r        <= fin_max;
            range_r      <= fin_rng;
            out_strobe_r <= 1'b1;
            out_data_r   <= '{cell_density: hdfu_pkg::DMASK, cell_level: lvl_r,
                              cell_filled: 1'b1, min_density: fin_min,
                              max_density: fin_max, density_range: fin_rng};
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // checks
  `AST_IMP(a_range_nonzero, clk, rst_n, out_strobe, out_data.density_range != '0)
  `AST_IMP(a_wb_not_placed, clk, rst_n, dv_r[NW], daddr_r[NW] != {row_r, col_r})
  `AST_IMP(a_pipe_only_place, clk, rst_n, pipe_busy,
           state_r == ST_SWEEP || state_r == ST_DRAIN)
  `AST_NXT(a_strobe_one_beat, clk, rst_n, out_strobe && busy, !out_strobe)

endmodule
